### hw/rtl/ucem_pkg.sv
// ----------------------------------------------------------------------------
// ucem_pkg: shared types, constants and functions
// Command and status codes, the AES S-box and the round helper functions used
// by the encryption map.
// ----------------------------------------------------------------------------
package ucem_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   localparam logic [2:0] CMD_ARM   = 3'd0;
   localparam logic [2:0] CMD_ADD   = 3'd1;
   localparam logic [2:0] CMD_GETE  = 3'd2;
   localparam logic [2:0] CMD_GETR  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_ARMED = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic          start;
      logic [127:0]  block;
   } aes_req_type;

   typedef struct packed {
      logic          done;
      logic [127:0]  block;
   } aes_rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit block sits at bits [127-8i -: 8].
   function automatic logic [7:0] byte_of(input logic [127:0] b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // One full AES round: SubBytes, ShiftRows and optionally MixColumns.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4 * c] = sbox(byte_of(s, r + 4 * ((c + r) & 3)));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (mix) begin
            t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = t[i];
      end
      return o;
   endfunction

endpackage

### hw/rtl/uuid_ctr_encrypt_map.sv
// ----------------------------------------------------------------------------
// uuid_ctr_encrypt_map: table of real and encrypted UUID pairs
// Appends pairs encrypted in counter mode under AES-256 and looks up partners.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been shown. The result sits on the rsp_ ports
// for exactly one cycle, marked by rsp_valid; the receiver cannot hold it off.
// Arm, clear, unused codes and refused requests go from start through the
// dispatch and response states to the result strobe. An add runs one AES-256
// block on the shared round unit, one round per cycle. A lookup scans the
// table one entry per cycle in insertion order through the registered read
// port of the stores, up to the fill count (sixteen at a full table), and
// stops early at the first match. The key registers are written through the
// csr_ port on csr_write; the user is to do so only at idle time, as the block
// does not enforce it. Reset clears them; neither arm nor clear touches them.
// Reset disarms the block and empties the table; the stores themselves are not
// cleared, since only entries below the fill count are ever compared.
// ----------------------------------------------------------------------------
module uuid_ctr_encrypt_map
   import ucem_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [2:0]    req_command,
   input  logic [63:0]   req_uuid_high,
   input  logic [63:0]   req_uuid_low,
   input  logic [7:0]    req_sector_byte,
   input  logic [7:0]    req_partition_index,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [63:0]   rsp_result_high,
   output logic [63:0]   rsp_result_low,
   output logic [4:0]    rsp_entry_count,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_AES  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]       st_ff, st_in;
   logic [255:0]     key_ff;
   logic [2:0]       cmd_ff;
   logic [127:0]     uuid_ff;
   logic [7:0]       sec_ff, part_ff;
   logic [CntW-1:0]  fill_ff, fill_in;
   logic             armed_ff, armed_in;
   logic [CntW-1:0]  scan_ff, scan_in;   // address of the entry being read
   logic             rdv_ff, rdv_in;     // read data is valid for scan_ff - 1
   logic [1:0]       status_ff, status_in;
   logic [127:0]     res_ff, res_in;
   logic             valid_ff, valid_in;
   logic             wr_en;
   logic             accept;
   logic [127:0]     rd_real, rd_enc;
   aes_req_type      aes_req;
   aes_rsp_type      aes_rsp;

   // A request is only taken once the previous result has left the ports.
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write) begin
         key_ff[255 - 64 * csr_index -: 64] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         uuid_ff <= {req_uuid_high, req_uuid_low};
         sec_ff  <= req_sector_byte;
         part_ff <= req_partition_index;
      end
   end

   // The counter block: sector, partition, 32-bit big-endian index, zeros.
   always_comb begin
      aes_req.start = 1'b0;
      aes_req.block = {sec_ff, part_ff, 32'(fill_ff), 80'd0};
      wr_en    = 1'b0;
      st_in    = st_ff;
      fill_in  = fill_ff;
      armed_in = armed_ff;
      scan_in  = scan_ff;
      rdv_in   = 1'b0;
      status_in = status_ff;
      res_in   = res_ff;
      valid_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               st_in = S_DISP;
            end
         end
         S_DISP: begin
            status_in = ST_OK;
            res_in    = '0;
            st_in     = S_RESP;
            scan_in   = '0;
            case (cmd_ff)
               CMD_ARM: begin
                  fill_in  = '0;
                  armed_in = 1'b1;
               end
               CMD_CLEAR: begin
                  fill_in  = '0;
                  armed_in = 1'b0;
               end
               CMD_ADD: begin
                  if (!armed_ff) begin
                     status_in = ST_NOT_ARMED;
                  end else if (fill_ff >= CntW'(TableDepth)) begin
                     status_in = ST_FULL;
                  end else begin
                     aes_req.start = 1'b1;
                     st_in = S_AES;
                  end
               end
               CMD_GETE, CMD_GETR: begin
                  if (!armed_ff) begin
                     status_in = ST_NOT_ARMED;
                  end else begin
                     status_in = ST_NOT_FOUND;
                     if (fill_ff != '0) begin
                        st_in   = S_SCAN;
                        scan_in = CntW'(1);
                        rdv_in  = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_AES: begin
            if (aes_rsp.done) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + CntW'(1);
               st_in   = S_RESP;
            end
         end
         S_SCAN: begin
            if (rdv_ff) begin
               if (cmd_ff == CMD_GETE ? rd_real == uuid_ff : rd_enc == uuid_ff) begin
                  status_in = ST_OK;
                  res_in    = (cmd_ff == CMD_GETE) ? rd_enc : rd_real;
                  st_in     = S_RESP;
               end else if (scan_ff >= fill_ff) begin
                  st_in = S_RESP;
               end else begin
                  scan_in = scan_ff + CntW'(1);
                  rdv_in  = 1'b1;
               end
            end
         end
         S_RESP: begin
            valid_in = 1'b1;
            st_in    = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         fill_ff  <= '0;
         armed_ff <= 1'b0;
         valid_ff <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         fill_ff  <= fill_in;
         armed_ff <= armed_in;
         valid_ff <= valid_in;
         rdv_ff   <= rdv_in;
      end
      scan_ff   <= scan_in;
      status_ff <= status_in;
      res_ff    <= res_in;
   end

   // Read address: entry 0 is read during dispatch, then scan_ff onwards.
   logic [IdxW-1:0] rd_addr;
   assign rd_addr = (st_ff == S_DISP) ? '0 : scan_ff[IdxW-1:0];

   ucem_ram #(.Width(128), .Depth(TableDepth)) u_real_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[IdxW-1:0]),
      .wr_data (uuid_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_real)
   );

   ucem_ram #(.Width(128), .Depth(TableDepth)) u_enc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[IdxW-1:0]),
      .wr_data (uuid_ff ^ aes_rsp.block),
      .rd_addr (rd_addr),
      .rd_data (rd_enc)
   );

   ucem_aes_core u_aes (
      .clock (clock),
      .reset (reset),
      .key   (key_ff),
      .req   (aes_req),
      .rsp   (aes_rsp)
   );

   assign busy            = st_ff != S_IDLE || valid_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_high = res_ff[127:64];
   assign rsp_result_low  = res_ff[63:0];
   assign rsp_entry_count = 5'(fill_ff);

endmodule

### hw/rtl/ucem_ram.sv
// ----------------------------------------------------------------------------
// ucem_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ucem_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ucem_aes_core.sv
// ----------------------------------------------------------------------------
// ucem_aes_core: iterative AES-256 encryption
// One round per cycle on a shared round unit, with the key schedule expanded
// alongside.
// ----------------------------------------------------------------------------
module ucem_aes_core
   import ucem_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [255:0]  key,
   input  aes_req_type   req,
   output aes_rsp_type   rsp
);

   logic [127:0] state_ff, state_in;
   logic [255:0] kw_ff, kw_in;      // words i-8 .. i-1 of the schedule window
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         done_ff, done_in;
   logic [127:0] nk;                // next four round-key words, as 128 bits
   logic [31:0]  w0, w1, w2, w3;
   logic [31:0]  sw;
   logic [127:0] rk;
   logic         even;

   // Round r uses words 4r..4r+3. Round 1 takes the low half of the key;
   // later rounds use freshly expanded words, with RotWord and rcon on even ones.
   always_comb begin
      even = ~round_ff[0];
      sw = sub_word(even ? {kw_ff[23:0], kw_ff[31:24]} : kw_ff[31:0]);
      w0 = kw_ff[255:224] ^ (even ? {sw[31:24] ^ rcon_ff, sw[23:0]} : sw);
      w1 = kw_ff[223:192] ^ w0;
      w2 = kw_ff[191:160] ^ w1;
      w3 = kw_ff[159:128] ^ w2;
      nk = {w0, w1, w2, w3};
      rk = nk;
      state_in = state_ff;
      kw_in    = kw_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      rcon_in  = rcon_ff;
      done_in  = 1'b0;
      if (req.start) begin
         state_in = req.block ^ key[255:128];
         kw_in    = key;
         round_in = 4'd1;
         busy_in  = 1'b1;
         rcon_in  = 8'h01;
      end else if (busy_ff) begin
         if (round_ff == 4'd1) begin
            rk = kw_ff[127:0];
         end else begin
            kw_in = {kw_ff[127:0], nk};
            if (even) begin
               rcon_in = xtime(rcon_ff);
            end
         end
         state_in = aes_round(state_ff, round_ff != 4'd14) ^ rk;
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd14) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      kw_ff    <= kw_in;
      rcon_ff  <= rcon_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.block = state_ff;

endmodule
